// File: rtl/core/srpg_pkg.sv
package srpg_pkg;

    // Field widths of the interface.
    localparam int SPEED_W     = 16;
    localparam int POS_W       = 32;
    localparam int ACC_W       = 15;
    localparam int MAXS_W      = 7;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 15;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ACCELERATION = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED    = CFG_INDEX_W'(1);

    // Braking distance arithmetic: |d| * acc, doubled, rounded up, scaled down.
    localparam int MAG_W      = POS_W;
    localparam int MULT_W     = MAG_W + ACC_W;
    localparam int PROD_W     = MULT_W + 1;
    localparam int RAD_RAW_W  = PROD_W - FRAC_BITS;
    localparam int ROOT_W     = (RAD_RAW_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int FRAC_MASK  = (1 << FRAC_BITS) - 1;

    // Working width for speed sums before saturation.
    localparam int SCALED_W = MAXS_W + FRAC_BITS + 1;
    localparam int WIDE_W   = (SCALED_W > SPEED_W + 2) ? SCALED_W : SPEED_W + 2;

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((2 ** (SPEED_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL,
        ST_START,
        ST_ROOT,
        ST_SPEED,
        ST_WRITE
    } srpg_state_t;

    typedef struct packed {
        logic use_position;
        logic negative;
    } srpg_shape_ctrl_t;

    typedef struct packed {
        logic in_ready;
        logic load_item;
        logic load_dist;
        logic load_prod;
        logic sqrt_start;
        logic load_speed;
        logic commit;
    } srpg_ctrl_t;

    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SPEED_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SPEED_W-1:0];
        end
        else
        begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/speed_ramp_position_generator.sv
// Channel   Direction  Handshake               Contents
// in        input      in_valid / in_ready     one servo tick: flags and targets
// out       output     out_valid / out_ready   position consign, speed, finished
// cfg       input      cfg_valid / cfg_ready   register index and write data
//
// A tick in position mode runs distance, multiply, root load, the square root unit
// (one root bit per cycle), speed shaping and commit; a tick in speed mode runs
// only speed shaping and commit, and an inactive tick only commit.
// Reset clears the speed, the position consign and both configuration registers.
// A result waits in the output register until taken; the next transaction is
// accepted meanwhile and is held at its commit step until the output is free.
module speed_ramp_position_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 active,
    input  logic                                 completion_check,
    input  logic                                 use_position,
    input  logic signed [srpg_pkg::SPEED_W-1:0]  speed_target,
    input  logic signed [srpg_pkg::POS_W-1:0]    position_target,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [srpg_pkg::POS_W-1:0]    position_consign,
    output logic signed [srpg_pkg::SPEED_W-1:0]  current_speed,
    output logic                                 finished,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srpg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    srpg_pkg::srpg_state_t state_reg;
    srpg_pkg::srpg_state_t state_next;
    srpg_pkg::srpg_ctrl_t  ctrl;

    // Configuration registers.
    logic [srpg_pkg::ACC_W-1:0]          acc_reg;
    logic [srpg_pkg::MAXS_W-1:0]         maxs_reg;

    // Axis state; it also serves as the output register.
    logic signed [srpg_pkg::SPEED_W-1:0] speed_reg;
    logic signed [srpg_pkg::POS_W-1:0]   pos_reg;
    logic                                fin_reg;
    logic                                out_valid_reg;

    // The accepted tick.
    logic                                act_reg;
    logic                                chk_reg;
    logic                                usep_reg;
    logic signed [srpg_pkg::SPEED_W-1:0] spt_reg;
    logic signed [srpg_pkg::POS_W-1:0]   pst_reg;

    // Working registers.
    logic [srpg_pkg::MAG_W-1:0]          mag_reg;
    logic                                neg_reg;
    logic [srpg_pkg::MULT_W-1:0]         prod_reg;
    logic signed [srpg_pkg::SPEED_W-1:0] new_speed_reg;

    logic signed [srpg_pkg::POS_W-1:0]   distance;
    logic [srpg_pkg::PROD_W-1:0]         rad_full;
    logic [srpg_pkg::RAD_W-1:0]          radicand;
    logic [srpg_pkg::ROOT_W-1:0]         root;
    logic                                sqrt_done;
    logic signed [srpg_pkg::SPEED_W-1:0] shaped_speed;
    logic signed [srpg_pkg::SPEED_W-1:0] whole;
    logic signed [srpg_pkg::POS_W-1:0]   pos_step;
    logic                                out_free;
    srpg_pkg::srpg_shape_ctrl_t          shape_ctrl;

    assign out_free = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // Distance to go, wrapping in 32 bits, and its magnitude.
    assign distance = pst_reg - pos_reg;

    // ceil(2 * |d| * acc / 2^FRAC_BITS) feeds the root unit.
    assign rad_full = {prod_reg, 1'b0} + srpg_pkg::PROD_W'(srpg_pkg::FRAC_MASK);
    assign radicand = srpg_pkg::RAD_W'(rad_full[srpg_pkg::PROD_W-1:srpg_pkg::FRAC_BITS]);

    // The consign moves by the speed's integer part, rounded toward minus infinity.
    assign whole    = new_speed_reg >>> srpg_pkg::FRAC_BITS;
    assign pos_step = srpg_pkg::POS_W'(whole);

    assign shape_ctrl.use_position = usep_reg;
    assign shape_ctrl.negative     = neg_reg;

    srpg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    srpg_shape u_shape (
        .speed_cur    (speed_reg),
        .speed_target (spt_reg),
        .acc          (acc_reg),
        .max_speed    (maxs_reg),
        .root         (root),
        .ctrl         (shape_ctrl),
        .speed_new    (shaped_speed)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!active)
                    begin
                        state_next = srpg_pkg::ST_WRITE;
                    end
                    else if (use_position)
                    begin
                        state_next = srpg_pkg::ST_DIST;
                    end
                    else
                    begin
                        state_next = srpg_pkg::ST_SPEED;
                    end
                end
            end
            srpg_pkg::ST_DIST:  state_next = srpg_pkg::ST_MUL;
            srpg_pkg::ST_MUL:   state_next = srpg_pkg::ST_START;
            srpg_pkg::ST_START: state_next = srpg_pkg::ST_ROOT;
            srpg_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = srpg_pkg::ST_SPEED;
                end
            end
            srpg_pkg::ST_SPEED: state_next = srpg_pkg::ST_WRITE;
            srpg_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = srpg_pkg::ST_IDLE;
                end
            end
            default:            state_next = srpg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: control outputs.
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            srpg_pkg::ST_IDLE:
            begin
                ctrl.in_ready  = 1'b1;
                ctrl.load_item = in_valid;
            end
            srpg_pkg::ST_DIST:  ctrl.load_dist  = 1'b1;
            srpg_pkg::ST_MUL:   ctrl.load_prod  = 1'b1;
            srpg_pkg::ST_START: ctrl.sqrt_start = 1'b1;
            srpg_pkg::ST_ROOT:  ctrl = '0;
            srpg_pkg::ST_SPEED: ctrl.load_speed = 1'b1;
            srpg_pkg::ST_WRITE: ctrl.commit     = out_free;
            default:            ctrl = '0;
        endcase
    end

    assign in_ready = ctrl.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            maxs_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srpg_pkg::REG_ACCELERATION: acc_reg  <= cfg_data[srpg_pkg::ACC_W-1:0];
                srpg_pkg::REG_MAX_SPEED:    maxs_reg <= cfg_data[srpg_pkg::MAXS_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Axis state and output handshake. The state only changes at commit, which
    // waits for a free output register, so it doubles as the result payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= '0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
            if (act_reg)
            begin
                speed_reg <= new_speed_reg;
                pos_reg   <= pos_reg + pos_step;
                fin_reg   <= chk_reg && usep_reg && (new_speed_reg == '0);
            end
            else
            begin
                fin_reg <= 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers for the tick in progress.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            act_reg  <= active;
            chk_reg  <= completion_check;
            usep_reg <= use_position;
            spt_reg  <= speed_target;
            pst_reg  <= position_target;
            neg_reg  <= 1'b0;
        end
        if (ctrl.load_dist)
        begin
            neg_reg <= distance[srpg_pkg::POS_W-1];
            mag_reg <= distance[srpg_pkg::POS_W-1] ? srpg_pkg::MAG_W'(-distance)
                                                   : srpg_pkg::MAG_W'(distance);
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= srpg_pkg::MULT_W'(mag_reg) * srpg_pkg::MULT_W'(acc_reg);
        end
        if (ctrl.load_speed)
        begin
            new_speed_reg <= shaped_speed;
        end
    end

    assign out_valid        = out_valid_reg;
    assign position_consign = pos_reg;
    assign current_speed    = speed_reg;
    assign finished         = fin_reg;

endmodule

// File: rtl/core/srpg_sqrt.sv
module srpg_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [srpg_pkg::RAD_W-1:0]     radicand,
    output logic                           done,
    output logic [srpg_pkg::ROOT_W-1:0]    root
);

    localparam int RW = srpg_pkg::ROOT_W;

    logic                               busy_reg;
    logic [srpg_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [srpg_pkg::RAD_W-1:0]         rad_reg;
    logic [RW:0]                        rem_reg;
    logic [RW-1:0]                      root_reg;

    logic [RW+2:0]                      rem_shift;
    logic [RW+2:0]                      trial;
    logic [RW+2:0]                      diff;
    logic                               take;

    // One root bit per cycle: bring down two radicand bits and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[srpg_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_shift - trial;
        take      = (rem_shift >= trial);
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= srpg_pkg::SQRT_CNT_W'(RW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[srpg_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= take ? diff[RW:0] : rem_shift[RW:0];
            root_reg <= {root_reg[RW-2:0], take};
        end
    end

endmodule

// File: rtl/core/srpg_shape.sv
module srpg_shape (
    input  logic signed [srpg_pkg::SPEED_W-1:0] speed_cur,
    input  logic signed [srpg_pkg::SPEED_W-1:0] speed_target,
    input  logic        [srpg_pkg::ACC_W-1:0]   acc,
    input  logic        [srpg_pkg::MAXS_W-1:0]  max_speed,
    input  logic        [srpg_pkg::ROOT_W-1:0]  root,
    input  srpg_pkg::srpg_shape_ctrl_t          ctrl,
    output logic signed [srpg_pkg::SPEED_W-1:0] speed_new
);

    localparam int WW = srpg_pkg::WIDE_W;

    logic signed [WW-1:0]                                       cur_w;
    logic signed [WW-1:0]                                       tgt_w;
    logic signed [WW-1:0]                                       acc_w;
    logic signed [WW-1:0]                                       diff_w;
    logic signed [WW-1:0]                                       mag_w;
    logic signed [WW-1:0]                                       lo_w;
    logic signed [WW-1:0]                                       hi_w;
    logic signed [WW-1:0]                                       scaled_w;
    logic signed [WW-1:0]                                       bound_w;
    logic signed [srpg_pkg::SPEED_W-1:0]                        scaled_sat;
    logic        [srpg_pkg::MAXS_W-1:0]                         capped;
    logic        [srpg_pkg::MAXS_W+srpg_pkg::FRAC_BITS-1:0]    mag_sc;

    always_comb
    begin
        cur_w  = WW'(speed_cur);
        tgt_w  = WW'(speed_target);
        acc_w  = $signed(WW'(acc));
        lo_w   = cur_w - acc_w;
        hi_w   = cur_w + acc_w;
        diff_w = tgt_w - cur_w;
        mag_w  = (diff_w < 0) ? -diff_w : diff_w;

        // Position mode: cap, sign, scale the braking speed and limit its step.
        if (root > srpg_pkg::ROOT_W'(max_speed))
        begin
            capped = max_speed;
        end
        else
        begin
            capped = root[srpg_pkg::MAXS_W-1:0];
        end
        mag_sc     = {capped, srpg_pkg::FRAC_BITS'(0)};
        scaled_w   = $signed(WW'(mag_sc));
        if (ctrl.negative)
        begin
            scaled_w = -scaled_w;
        end
        scaled_sat = srpg_pkg::sat_speed(scaled_w);
        bound_w    = WW'(scaled_sat);
        if (bound_w < lo_w)
        begin
            bound_w = lo_w;
        end
        else if (bound_w > hi_w)
        begin
            bound_w = hi_w;
        end

        if (ctrl.use_position)
        begin
            speed_new = srpg_pkg::sat_speed(bound_w);
        end
        else if (mag_w < acc_w)
        begin
            speed_new = speed_target;
        end
        else if (tgt_w > cur_w)
        begin
            speed_new = srpg_pkg::sat_speed(hi_w);
        end
        else
        begin
            speed_new = srpg_pkg::sat_speed(lo_w);
        end
    end

endmodule

// File: sim/tb.sv
module tb;

    import srpg_pkg::*;

    // Speed extremes of the signed f8.8 field.
    localparam logic signed [SPEED_W-1:0] SPEED_TOP    = 16'sh7fff;
    localparam logic signed [SPEED_W-1:0] SPEED_BOTTOM = 16'sh8000;

    // The long receiver hold-off, and how many quiet cycles the watchdog tolerates.
    // The slowest tick, the longest sender gap and the hold-off all lie far below the
    // limit, which sits several times above any correct run.
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 228;

    // One servo tick as presented on the input channel.
    typedef struct {
        logic                       act;
        logic                       chk;
        logic                       use_pos;
        logic signed [SPEED_W-1:0]  spd_target;
        logic signed [POS_W-1:0]    pos_target;
    } tick_t;

    // One result transaction: the new consign, the new speed and the finish flag.
    typedef struct {
        logic signed [POS_W-1:0]    consign;
        logic signed [SPEED_W-1:0]  speed;
        logic                       fin;
    } consign_t;

    // Kinds of random segments. A move holds one goal position for many ticks so
    // that the axis accelerates, cruises, brakes and finishes; a cruise ramps toward
    // a target speed; noise is fully random, inactive ticks included.
    typedef enum int {
        SEG_MOVE,
        SEG_CRUISE,
        SEG_NOISE
    } seg_kind_t;

    // The scoreboard carries its own copy of the axis state and the two registers.
    // Every accepted tick advances that copy and queues the result it must produce;
    // every accepted result is compared with the oldest queued one.
    class axis_scoreboard;
        logic [ACC_W-1:0]           acc      = '0;
        logic [MAXS_W-1:0]          max_spd  = '0;
        logic signed [SPEED_W-1:0]  speed    = '0;
        logic signed [POS_W-1:0]    pos      = '0;
        consign_t                   consign_queue[$];
        int                         errors   = 0;
        int                         compared = 0;
        int                         finishes = 0;

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ACCELERATION)
            begin
                acc = data[ACC_W-1:0];
            end
            else if (idx == REG_MAX_SPEED)
            begin
                max_spd = data[MAXS_W-1:0];
            end
        endfunction

        function longint clamp16(longint v);
            if (v > longint'(SPEED_TOP))
            begin
                return longint'(SPEED_TOP);
            end
            if (v < longint'(SPEED_BOTTOM))
            begin
                return longint'(SPEED_BOTTOM);
            end
            return v;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= x)
                begin
                    r = t;
                end
            end
            return r;
        endfunction

        // Speed mode: step toward the target by the acceleration, or land on it
        // when it is closer than one step.
        function longint ramp_toward(logic signed [SPEED_W-1:0] target);
            longint c;
            longint tg;
            longint a;
            longint mag;
            c = speed;
            tg = target;
            a = acc;
            mag = (tg > c) ? tg - c : c - tg;
            if (mag < a)
            begin
                return tg;
            end
            if (tg > c)
            begin
                return clamp16(c + a);
            end
            return clamp16(c - a);
        endfunction

        // Position mode: the fastest speed from which the axis can still brake
        // within the remaining distance, capped, signed, scaled and rate limited.
        function longint brake_limited(logic signed [POS_W-1:0] target);
            logic signed [POS_W-1:0] d;
            longint unsigned         mag;
            longint unsigned         root;
            longint                  c;
            longint                  a;
            longint                  s;
            c = speed;
            a = acc;
            d = target - pos;
            if (d < 0)
            begin
                mag = -longint'(d);
            end
            else
            begin
                mag = longint'(d);
            end
            root = root_floor((2 * mag * longint'(acc) + FRAC_MASK) >> FRAC_BITS);
            if (root > max_spd)
            begin
                root = max_spd;
            end
            s = longint'(root);
            if (d < 0)
            begin
                s = -s;
            end
            s = clamp16(s * (1 << FRAC_BITS));
            if (s < c - a)
            begin
                s = c - a;
            end
            else if (s > c + a)
            begin
                s = c + a;
            end
            return clamp16(s);
        endfunction

        function void note_tick(tick_t t);
            consign_t e;
            longint   cur;
            e.fin = 1'b0;
            if (t.act)
            begin
                if (t.use_pos)
                begin
                    cur = brake_limited(t.pos_target);
                end
                else
                begin
                    cur = ramp_toward(t.spd_target);
                end
                speed = cur[SPEED_W-1:0];
                // The arithmetic shift rounds the integer part toward minus infinity.
                pos = pos + POS_W'(cur >>> FRAC_BITS);
                e.fin = t.chk && t.use_pos && (cur == 0);
            end
            e.consign = pos;
            e.speed = speed;
            consign_queue.push_back(e);
        endfunction

        function void check_consign(logic signed [POS_W-1:0] consign,
                                    logic signed [SPEED_W-1:0] spd, logic fin);
            consign_t e;
            if (consign_queue.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with no tick pending (consign %0d)",
                         $time, consign);
                return;
            end
            e = consign_queue.pop_front();
            compared++;
            if (e.fin)
            begin
                finishes++;
            end
            if (consign !== e.consign)
            begin
                errors++;
                $display("%0t: position_consign mismatch, expected %0d, actual %0d",
                         $time, e.consign, consign);
            end
            if (spd !== e.speed)
            begin
                errors++;
                $display("%0t: current_speed mismatch, expected %0d, actual %0d",
                         $time, e.speed, spd);
            end
            if (fin !== e.fin)
            begin
                errors++;
                $display("%0t: finished mismatch, expected %0b, actual %0b",
                         $time, e.fin, fin);
            end
        endfunction

        function int pending();
            return consign_queue.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n            = 1'b0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic                       active           = 1'b0;
    logic                       completion_check = 1'b0;
    logic                       use_position     = 1'b0;
    logic signed [SPEED_W-1:0]  speed_target     = '0;
    logic signed [POS_W-1:0]    position_target  = '0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic signed [POS_W-1:0]    position_consign;
    logic signed [SPEED_W-1:0]  current_speed;
    logic                       finished;
    logic                       cfg_valid        = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index        = '0;
    logic [CFG_DATA_W-1:0]      cfg_data         = '0;

    axis_scoreboard sb = new;

    // Shared between the stimulus process and the receiver process. The calm flag
    // removes all idling on both sides for one phase; hold_req asks the receiver
    // for one long hold-off while the sender keeps offering ticks.
    bit        calm       = 1'b0;
    bit        hold_req   = 1'b0;
    int        ticks_sent = 0;
    int        settings   = 0;
    int        holds      = 0;

    // Random segment state of the tick generator.
    seg_kind_t                 seg_kind  = SEG_NOISE;
    int                        seg_left  = 0;
    logic signed [POS_W-1:0]   seg_goal  = '0;
    logic signed [SPEED_W-1:0] seg_speed = '0;

    speed_ramp_position_generator DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .active           (active),
        .completion_check (completion_check),
        .use_position     (use_position),
        .speed_target     (speed_target),
        .position_target  (position_target),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .position_consign (position_consign),
        .current_speed    (current_speed),
        .finished         (finished),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle gaps: half of them zero, most of the rest short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // A speed target: the extremes and the smallest nonzero speeds now and then,
    // small values often, anything at all the rest of the time.
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
        begin
            case ($urandom_range(0, 4))
                0:       return SPEED_TOP;
                1:       return SPEED_BOTTOM;
                2:       return 16'sd1;
                3:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        if (r < 10)
        begin
            return SPEED_W'($signed($urandom_range(0, 2048)) - 1024);
        end
        return SPEED_W'($urandom);
    endfunction

    // A goal for a move, relative to where the predicted consign stands: mostly
    // close enough to arrive and finish, sometimes far, sometimes anywhere so that
    // the distance wraps.
    function automatic logic signed [POS_W-1:0] pick_goal();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
        begin
            return sb.pos;
        end
        if (r < 12)
        begin
            return sb.pos + POS_W'($signed($urandom_range(0, 600)) - 300);
        end
        if (r < 17)
        begin
            return sb.pos + POS_W'($signed($urandom_range(0, 40000)) - 20000);
        end
        return POS_W'($urandom);
    endfunction

    function automatic tick_t next_random_tick();
        tick_t t;
        int    r;
        if (seg_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                seg_kind = SEG_MOVE;
                seg_left = $urandom_range(10, 120);
                seg_goal = pick_goal();
            end
            else if (r < 85)
            begin
                seg_kind = SEG_CRUISE;
                seg_left = $urandom_range(5, 30);
                seg_speed = pick_speed();
            end
            else
            begin
                seg_kind = SEG_NOISE;
                seg_left = $urandom_range(1, 5);
            end
        end
        seg_left--;
        // Fields that the current mode ignores still carry random content.
        t.act = ($urandom_range(0, 19) != 0);
        t.chk = ($urandom_range(0, 9) < 7);
        t.spd_target = SPEED_W'($urandom);
        t.pos_target = POS_W'($urandom);
        case (seg_kind)
            SEG_MOVE:
            begin
                t.use_pos = 1'b1;
                t.pos_target = seg_goal;
            end
            SEG_CRUISE:
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    seg_speed = pick_speed();
                end
                t.use_pos = 1'b0;
                t.spd_target = seg_speed;
            end
            default:
            begin
                t.act = ($urandom_range(0, 1) == 1);
                t.use_pos = ($urandom_range(0, 1) == 1);
                t.spd_target = pick_speed();
            end
        endcase
        return t;
    endfunction

    // Offers one tick after an optional gap and returns at the edge that accepts
    // it. With no gap, valid simply stays high and the payload changes in place.
    task automatic send_tick(input tick_t t, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        active <= t.act;
        completion_check <= t.chk;
        use_position <= t.use_pos;
        speed_target <= t.spd_target;
        position_target <= t.pos_target;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_tick(t);
        ticks_sent++;
    endtask

    task automatic directed(input logic act, input logic chk, input logic use_pos,
                            input logic signed [SPEED_W-1:0] spd,
                            input logic signed [POS_W-1:0] goal);
        tick_t t;
        t.act = act;
        t.chk = chk;
        t.use_pos = use_pos;
        t.spd_target = spd;
        t.pos_target = goal;
        send_tick(t, idle_len());
    endtask

    // Leaves cfg_valid high on return so that back-to-back writes never lower and
    // raise it in the same step; load_setting lowers it after the last write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_register(idx, data);
    endtask

    // Writes both registers, with random bits above the speed cap field, and now
    // and then a write to an index past the register list, which must be ignored.
    task automatic load_setting(input logic [ACC_W-1:0] a, input logic [MAXS_W-1:0] m);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[MAXS_W-1:0] = m;
        write_register(REG_ACCELERATION, CFG_DATA_W'(a));
        write_register(REG_MAX_SPEED, data);
        if ($urandom_range(0, 1) == 1)
        begin
            write_register(CFG_INDEX_W'($urandom_range(REG_MAX_SPEED + 1,
                                                       (1 << CFG_INDEX_W) - 1)),
                           CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Waits until every queued result has been taken. The queue is looked at on
    // the falling edge, when all updates of the rising edge have settled, and the
    // task returns on the next rising edge so that driving resumes there.
    task automatic wait_drained();
        @(negedge clk);
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Results are sampled on the rising edge; the values seen here are the ones
    // from before the edge, so the check never races the block's own updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_consign(position_consign, current_speed, finished);
        end
    end

    // The receiver alternates random stall gaps and ready bursts, and takes one
    // long hold-off whenever the stimulus asks for it.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
                holds++;
            end
            else
            begin
                n = idle_len();
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk);
        end
    end

    // The watchdog ends a hung run: it counts cycles in which no transaction moves
    // on any of the three channels.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("** speed_ramp_position_generator: FAILED **");
        $finish;
    end

    initial
    begin
        logic [ACC_W-1:0]  a;
        logic [MAXS_W-1:0] m;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset settings: zero acceleration keeps the
        // speed at zero, so a position tick with the check flag finishes at once,
        // and an inactive tick holds everything.
        directed(1'b1, 1'b0, 1'b0, SPEED_TOP, 32'sd0);
        directed(1'b1, 1'b1, 1'b1, 16'sd0, 32'sd1000);
        directed(1'b0, 1'b1, 1'b1, -16'sd1, -32'sd1);
        in_valid <= 1'b0;
        wait_drained();

        // Largest acceleration and speed cap: the speed reaches both extremes, one
        // step exactly covers the distance to a speed target, and the far position
        // targets make the distance wrap.
        load_setting({ACC_W{1'b1}}, {MAXS_W{1'b1}});
        directed(1'b1, 1'b0, 1'b0, SPEED_TOP, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, SPEED_TOP, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, SPEED_BOTTOM, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, SPEED_BOTTOM, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, SPEED_BOTTOM, 32'sd0);
        directed(1'b0, 1'b1, 1'b1, SPEED_W'($urandom), POS_W'($urandom));
        directed(1'b1, 1'b1, 1'b0, 16'sd1, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, -16'sd1, 32'sd0);
        directed(1'b1, 1'b0, 1'b0, 16'sd0, 32'sd0);
        directed(1'b1, 1'b1, 1'b1, 16'sd0, 32'sh7fffffff);
        directed(1'b1, 1'b1, 1'b1, 16'sd0, 32'sh80000000);
        // Holding the goal at the consign brakes the axis to a stop and finishes.
        repeat (4) directed(1'b1, 1'b1, 1'b1, 16'sd0, sb.pos);
        directed(1'b1, 1'b0, 1'b1, 16'sd0, sb.pos);
        directed(1'b1, 1'b1, 1'b1, 16'sd0, sb.pos + 32'sd1);
        directed(1'b1, 1'b1, 1'b1, 16'sd0, sb.pos - 32'sd1);
        in_valid <= 1'b0;

        // Random phases, each with its own register setting. Every phase ends with
        // the sender paused until the last result has arrived, so registers are
        // only written while the block is idle.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    a = {ACC_W{1'b1}};
                    m = {MAXS_W{1'b1}};
                end
                1:
                begin
                    a = ACC_W'(256);
                    m = MAXS_W'(16);
                end
                2:
                begin
                    a = ACC_W'($urandom_range(1, 1024));
                    m = MAXS_W'($urandom);
                end
                3:
                begin
                    a = '0;
                    m = MAXS_W'($urandom);
                end
                4:
                begin
                    a = ACC_W'($urandom);
                    m = '0;
                end
                5:
                begin
                    a = ACC_W'(1);
                    m = MAXS_W'(1);
                end
                6:
                begin
                    a = ACC_W'($urandom_range(64, 4096));
                    m = {MAXS_W{1'b1}};
                end
                default:
                begin
                    a = ACC_W'($urandom);
                    m = MAXS_W'($urandom);
                end
            endcase
            load_setting(a, m);
            calm = (phase == 5);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // Mid-phase in two phases, the receiver stops for a long stretch
                // while ticks keep coming, so the block fills up and stalls.
                if ((phase == 2 || phase == 6) && i == 100)
                begin
                    hold_req = 1'b1;
                end
                send_tick(next_random_tick(), idle_len());
            end
            in_valid <= 1'b0;
        end
        calm = 1'b0;

        wait_drained();
        // A few more cycles to catch any result the block should not produce.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d ticks over %0d register settings with %0d long receiver hold-offs;",
                 ticks_sent, settings, holds);
        $display("compared %0d results, %0d of them finished moves, %0d mismatches.",
                 sb.compared, sb.finishes, sb.errors);
        if (sb.errors == 0)
        begin
            $display("** speed_ramp_position_generator: PASSED **");
        end
        else
        begin
            $display("** speed_ramp_position_generator: FAILED **");
        end
        $finish;
    end

endmodule
